// ===== hw/rtl/encoder_multiturn_velocity_tracker_assert.svh =====
// assertion macros shared by the tracker rtl
// expects clk and rst_n in the including module
`ifndef ENCODER_MULTITURN_VELOCITY_TRACKER_ASSERT_SVH
`define ENCODER_MULTITURN_VELOCITY_TRACKER_ASSERT_SVH

// same-cycle implication
`define EMTV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("emtv assertion failed");

// next-cycle implication
`define EMTV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emtv assertion failed");

`endif

// ===== hw/rtl/emtv_pkg.sv =====
// shared widths, reset values, codes and control structs of the tracker
// no dependencies
package emtv_pkg;

    localparam int ANGLE_BITS_DEF = 12;

    localparam int BYTE_W      = 8;
    localparam int THRESH_W    = 12;
    localparam int TPS_W       = 20;
    localparam int INTERVAL_W  = 16;
    localparam int ANGLE_OUT_W = 12;
    localparam int TURN_W      = 32;
    localparam int POS_W       = 44;
    localparam int VEL_W       = 33;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = TPS_W;

    localparam logic [THRESH_W-1:0] THRESH_RST = 12'd3276;
    localparam logic [TPS_W-1:0]    TPS_RST    = 20'd1000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 2'd1;

    // operation codes
    localparam logic OP_INIT = 1'b0;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_init;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/encoder_multiturn_velocity_tracker.sv =====
// multi-turn angle tracker with velocity estimate; top level over emtv_ctrl and emtv_dp
// update request: capture, multiply, divider start, then the one-bit-per-cycle divider
//   over the ANGLE_BITS + 21 bit scaled jump, then load; initialise skips to the load
// one request at a time; a finished result waits behind an unaccepted one before it
//   is loaded, and no new request is taken meanwhile
// reset: async active low; threshold 3276, ticks per second 1000, angle and turns zero
module encoder_multiturn_velocity_tracker #(
    parameter int ANGLE_BITS = emtv_pkg::ANGLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [emtv_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [emtv_pkg::CFG_DATA_W-1:0]        cfg_data,
    // request channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   operation,
    input  logic [emtv_pkg::BYTE_W-1:0]            angle_high_byte,
    input  logic [emtv_pkg::BYTE_W-1:0]            angle_low_byte,
    input  logic [emtv_pkg::INTERVAL_W-1:0]        interval_ticks,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [emtv_pkg::ANGLE_OUT_W-1:0]       angle_counts,
    output logic signed [emtv_pkg::TURN_W-1:0]     turn_count,
    output logic signed [emtv_pkg::POS_W-1:0]      position_counts,
    output logic signed [emtv_pkg::VEL_W-1:0]      velocity
);

    // command and status between controller and datapath
    emtv_pkg::ctrl_cmd_t  cmd;
    emtv_pkg::dp_status_t status;

    // controller: idle takes a request, then multiply, divide and load the result (initialise goes straight to load);
    // the result register lets the next request in while a result waits
    emtv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: turn detection and state update at accept, then
    // |jump| * ticks_per_second / interval, sign restored at load
    emtv_dp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .angle_high_byte (angle_high_byte),
        .angle_low_byte  (angle_low_byte),
        .interval_ticks  (interval_ticks),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .angle_counts    (angle_counts),
        .turn_count      (turn_count),
        .position_counts (position_counts),
        .velocity        (velocity)
    );

endmodule

// ===== hw/rtl/emtv_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on emtv_pkg
module emtv_div #(
    parameter int DW = emtv_pkg::ANGLE_BITS_DEF + 1 + emtv_pkg::TPS_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [DW-1:0]                   dividend,
    input  logic [emtv_pkg::INTERVAL_W-1:0] divisor,
    output logic [DW-1:0]                   quotient,
    output logic                            done
);

    localparam int IW    = emtv_pkg::INTERVAL_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [IW-1:0]    dvs_reg, dvs_next;

    logic [IW:0] shifted;
    logic [IW:0] diff;
    logic        ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[IW-1:0] : shifted[IW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hw/rtl/emtv_dp.sv =====
// datapath: config registers, turn tracking, scaling multiply, divider, output register
// depends on emtv_pkg, emtv_div and the assertion header
`include "encoder_multiturn_velocity_tracker_assert.svh"

module emtv_dp #(
    parameter int ANGLE_BITS = emtv_pkg::ANGLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  emtv_pkg::ctrl_cmd_t                    cmd,
    output emtv_pkg::dp_status_t                   status,
    input  logic                                   cfg_we,
    input  logic [emtv_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [emtv_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   operation,
    input  logic [emtv_pkg::BYTE_W-1:0]            angle_high_byte,
    input  logic [emtv_pkg::BYTE_W-1:0]            angle_low_byte,
    input  logic [emtv_pkg::INTERVAL_W-1:0]        interval_ticks,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [emtv_pkg::ANGLE_OUT_W-1:0]       angle_counts,
    output logic signed [emtv_pkg::TURN_W-1:0]     turn_count,
    output logic signed [emtv_pkg::POS_W-1:0]      position_counts,
    output logic signed [emtv_pkg::VEL_W-1:0]      velocity
);

    localparam int AB     = ANGLE_BITS;
    localparam int TW     = emtv_pkg::TURN_W;
    localparam int IW     = emtv_pkg::INTERVAL_W;
    localparam int PROD_W = AB + 1 + emtv_pkg::TPS_W;
    localparam int CMP_W  = (AB > emtv_pkg::THRESH_W) ? AB : emtv_pkg::THRESH_W;
    localparam int ANG_EW = (AB > emtv_pkg::ANGLE_OUT_W) ? AB : emtv_pkg::ANGLE_OUT_W;
    localparam int POS_LW = (TW + AB > emtv_pkg::POS_W) ? TW + AB : emtv_pkg::POS_W;
    localparam int VEL_LW = (PROD_W + 1 > emtv_pkg::VEL_W) ? PROD_W + 1 : emtv_pkg::VEL_W;
    localparam logic [AB+1:0] CPT_EXT = {2'b01, {AB{1'b0}}};

    // architectural state and config
    logic [emtv_pkg::THRESH_W-1:0] thresh_reg;
    logic [emtv_pkg::TPS_W-1:0]    tps_reg;
    logic [AB-1:0]                 prev_angle_reg;
    logic [TW-1:0]                 rot_reg, rot_next;
    logic                          out_valid_reg, out_valid_next;

    // per-request working registers
    logic [AB-1:0]     angle_reg;
    logic [TW-1:0]     turns_reg;
    logic [AB:0]       mag_reg;
    logic              neg_reg;
    logic              init_reg;
    logic [IW-1:0]     interval_reg;
    logic [PROD_W-1:0] prod_reg;

    // result registers
    logic [emtv_pkg::ANGLE_OUT_W-1:0] angle_out_reg;
    logic [TW-1:0]                    turn_out_reg;
    logic [emtv_pkg::POS_W-1:0]       pos_out_reg;
    logic [emtv_pkg::VEL_W-1:0]       vel_out_reg;

    logic [2*emtv_pkg::BYTE_W-1:0] raw;
    logic [AB-1:0]     angle_in;
    logic [AB:0]       diff, diff_neg;
    logic [AB-1:0]     diff_mag;
    logic              big, turn_inc, turn_dec, op_init;
    logic [AB+1:0]     total, total_neg_v;
    logic [AB:0]       total_mag;
    logic [PROD_W-1:0] quotient;
    logic              div_done;
    logic [ANG_EW-1:0] angle_ext;
    logic [POS_LW-1:0] pos_wide;
    logic [VEL_LW-1:0] q_ext, q_neg, vel_sel;

    always_comb
    begin
        raw         = {angle_high_byte, angle_low_byte};
        angle_in    = raw[AB-1:0];
        op_init     = (operation == emtv_pkg::OP_INIT);
        diff        = {1'b0, angle_in} - {1'b0, prev_angle_reg};
        diff_neg    = -diff;
        diff_mag    = diff[AB] ? diff_neg[AB-1:0] : diff[AB-1:0];
        big         = (CMP_W'(diff_mag) > CMP_W'(thresh_reg));
        // a backward jump means the shaft wrapped forward
        turn_inc    = big & diff[AB];
        turn_dec    = big & ~diff[AB];
        if (turn_inc)
        begin
            total    = {diff[AB], diff} + CPT_EXT;
            rot_next = rot_reg + TW'(1);
        end
        else if (turn_dec)
        begin
            total    = {diff[AB], diff} - CPT_EXT;
            rot_next = rot_reg - TW'(1);
        end
        else
        begin
            total    = {diff[AB], diff};
            rot_next = rot_reg;
        end
        total_neg_v = -total;
        total_mag   = total[AB+1] ? total_neg_v[AB:0] : total[AB:0];

        angle_ext = ANG_EW'(angle_reg);
        pos_wide  = ({{(POS_LW-TW){turns_reg[TW-1]}}, turns_reg} << AB) + POS_LW'(angle_reg);
        q_ext     = VEL_LW'(quotient);
        q_neg     = -q_ext;
        if (init_reg)
            vel_sel = '0;
        else
            vel_sel = neg_reg ? q_neg : q_ext;

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= emtv_pkg::THRESH_RST;
            tps_reg        <= emtv_pkg::TPS_RST;
            prev_angle_reg <= '0;
            rot_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    emtv_pkg::CFG_WRAP_THRESHOLD:
                        thresh_reg <= cfg_data[emtv_pkg::THRESH_W-1:0];
                    emtv_pkg::CFG_TICKS_PER_SECOND:
                        tps_reg <= cfg_data;
                    default:
                        ;
                endcase
            end
            if (cmd.capture)
            begin
                prev_angle_reg <= angle_in;
                rot_reg        <= op_init ? '0 : rot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            angle_reg    <= angle_in;
            turns_reg    <= op_init ? '0 : rot_next;
            mag_reg      <= total_mag;
            neg_reg      <= total[AB+1];
            init_reg     <= op_init;
            interval_reg <= (interval_ticks == '0) ? IW'(1) : interval_ticks;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(tps_reg);
        if (cmd.load_out)
        begin
            angle_out_reg <= angle_ext[emtv_pkg::ANGLE_OUT_W-1:0];
            turn_out_reg  <= turns_reg;
            pos_out_reg   <= pos_wide[emtv_pkg::POS_W-1:0];
            vel_out_reg   <= vel_sel[emtv_pkg::VEL_W-1:0];
        end
    end

    emtv_div #(
        .DW (PROD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (interval_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        status.op_init  = op_init;
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign angle_counts    = angle_out_reg;
    assign turn_count      = turn_out_reg;
    assign position_counts = pos_out_reg;
    assign velocity        = vel_out_reg;

    `EMTV_ASSERT_IMPL(a_no_overwrite, cmd.load_out, status.out_free)
    `EMTV_ASSERT_NEXT(a_init_result, cmd.load_out && init_reg, velocity == '0 && turn_count == '0)

endmodule

// ===== hw/rtl/emtv_ctrl.sv =====
// controller state machine sequencing capture, multiply, divide and output load; initialise skips to the load
// depends on emtv_pkg and the assertion header
`include "encoder_multiturn_velocity_tracker_assert.svh"

module emtv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output emtv_pkg::ctrl_cmd_t  cmd,
    input  emtv_pkg::dp_status_t status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DIVGO  = 3'd2;
    localparam logic [2:0] S_DIVRUN = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.op_init ? S_DONE : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVRUN;
            end
            S_DIVRUN:
            begin
                if (status.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    `EMTV_ASSERT_IMPL(a_done_in_run, status.div_done, state_reg == S_DIVRUN)
    `EMTV_ASSERT_NEXT(a_init_skips_div, in_valid && in_ready && status.op_init, state_reg == S_DONE)

endmodule
